/* rtl/ght_pkg.sv */
// ----------------------------------------------------------------------------
// ght_pkg
// Types, codes and helpers shared by the growing chained hash table.
// ----------------------------------------------------------------------------
package ght_pkg;

  localparam int unsigned MaxBucketBits = 5;
  localparam int unsigned MaxBucketSize = 8;
  localparam int unsigned KeyLowW       = 64;
  localparam int unsigned KeyHighW      = 56;
  localparam int unsigned ValueW        = 16;
  localparam int unsigned HashW         = 16;
  localparam int unsigned KeyBytes      = 15;
  localparam int unsigned CfgIdxW       = 1;
  localparam int unsigned CfgDataW      = 4;
  localparam int unsigned InitBitsW     = 3;
  localparam int unsigned SizeRawW      = 4;

  localparam logic [CfgIdxW-1:0] CfgInitBits   = 1'b0;
  localparam logic [CfgIdxW-1:0] CfgBucketSize = 1'b1;

  localparam logic [InitBitsW-1:0] InitBitsRst = 3'd3;
  localparam logic [SizeRawW-1:0]  SizeRawRst  = 4'd8;

  localparam logic ReqLookup = 1'b0;
  localparam logic ReqInsert = 1'b1;

  typedef enum logic [1:0] {
    StOk       = 2'd0,
    StNotFound = 2'd1,
    StFull     = 2'd2
  } status_e;

  typedef struct packed {
    logic                     req_type;
    logic [KeyLowW-1:0]       key_low;
    logic [KeyHighW-1:0]      key_high;
    logic signed [ValueW-1:0] value;
  } req_t;

  typedef struct packed {
    status_e                  status;
    logic signed [ValueW-1:0] result_value;
  } rsp_t;

  typedef struct packed {
    logic                     req_type;
    logic [KeyLowW-1:0]       key_low;
    logic [KeyHighW-1:0]      key_high;
    logic signed [ValueW-1:0] value;
    logic [HashW-1:0]         hash;
  } work_t;

  typedef enum logic [1:0] {
    FeIdle,
    FeHash,
    FePush
  } fe_state_e;

  typedef enum logic [2:0] {
    BeIdle,
    BeLkRd,
    BeLkChk,
    BeInsChk,
    BeGrBkt,
    BeGrWr,
    BeIns
  } be_state_e;

  function automatic logic [HashW-1:0] hash_step(logic [HashW-1:0] h, logic [7:0] b);
    logic [HashW-1:0] s;
    s = h + {8'd0, b};
    return (s << 5) - s;
  endfunction

endpackage

/* rtl/growing_chained_hash_table_core.sv */
// ----------------------------------------------------------------------------
// growing_chained_hash_table_core
// Hash table of short keys with chained buckets that doubles its bucket count.
// ----------------------------------------------------------------------------
// The input channel takes one request beat (lookup or insert) and the output
// channel returns exactly one result beat per request, in order. The config
// channel writes the initial bucket bits or the bucket size; a write clears
// the whole table and is always ready.
// The front hashes one key byte per cycle, up to 15 bytes, and is ready
// again after it hands the item to a two-entry queue. The back handles one
// item at a time: a lookup reads and compares one bucket entry after another;
// an insert may first grow the table and then stores the entry if the bucket
// has room. Growth walks every old bucket and reads each stored entry from
// the entry store and writes it back into its old or its new bucket.
// Reset clears all bucket counts at once, so no clearing pass is needed.
// A stalled receiver holds the result register; the queue then fills and
// the input channel stops accepting.
// ----------------------------------------------------------------------------
module growing_chained_hash_table_core import ght_pkg::*; #(
  parameter int unsigned MaxBits = MaxBucketBits,
  parameter int unsigned MaxSize = MaxBucketSize
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  req_t                in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output rsp_t                out_data_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  logic  push, full, pop, empty;
  work_t fe_work, q_work;

  assign cfg_ready_o = 1'b1;

  ght_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_ready_o(in_ready_o),
    .in_data_i (in_data_i),
    .push_o    (push),
    .full_i    (full),
    .work_o    (fe_work)
  );

  ght_fifo u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .wdata_i(fe_work),
    .full_o (full),
    .pop_i  (pop),
    .empty_o(empty),
    .rdata_o(q_work)
  );

  ght_back #(
    .MaxBits(MaxBits),
    .MaxSize(MaxSize)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_valid_i(cfg_valid_i),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i),
    .empty_i    (empty),
    .work_i     (q_work),
    .pop_o      (pop),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

endmodule

/* rtl/ght_ram.sv */
// ----------------------------------------------------------------------------
// ght_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module ght_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

/* rtl/ght_front.sv */
// ----------------------------------------------------------------------------
// ght_front
// Accepts requests, clears key bytes after the terminator and hashes the
// key one byte per cycle before handing the item to the queue.
// ----------------------------------------------------------------------------
module ght_front import ght_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  output logic  in_ready_o,
  input  req_t  in_data_i,
  output logic  push_o,
  input  logic  full_i,
  output work_t work_o
);

  fe_state_e state_q, state_d;
  work_t     work_q, work_d;
  logic [3:0] cnt_q, cnt_d;
  logic [8*KeyBytes-1:0] key_in, key_norm, key_cur;
  logic [7:0] cur_byte;
  logic       seen_zero;

  always_comb begin
    key_in    = {in_data_i.key_high, in_data_i.key_low};
    key_norm  = key_in;
    seen_zero = 1'b0;
    for (int i = 0; i < KeyBytes; i++) begin
      if (key_in[8*i +: 8] == 8'd0) begin
        seen_zero = 1'b1;
      end
      if (seen_zero) begin
        key_norm[8*i +: 8] = 8'd0;
      end
    end
  end

  assign key_cur  = {work_q.key_high, work_q.key_low};
  assign cur_byte = key_cur[8*cnt_q +: 8];

  always_comb begin
    state_d    = state_q;
    work_d     = work_q;
    cnt_d      = cnt_q;
    in_ready_o = 1'b0;
    push_o     = 1'b0;
    case (state_q)
      FeIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          work_d.req_type = in_data_i.req_type;
          work_d.key_low  = key_norm[KeyLowW-1:0];
          work_d.key_high = key_norm[8*KeyBytes-1:KeyLowW];
          work_d.value    = in_data_i.value;
          work_d.hash     = '0;
          cnt_d           = '0;
          state_d         = FeHash;
        end
      end
      FeHash: begin
        if (cur_byte == 8'd0) begin
          state_d = FePush;
        end else begin
          work_d.hash = hash_step(work_q.hash, cur_byte);
          if (cnt_q == 4'(KeyBytes - 1)) begin
            state_d = FePush;
          end else begin
            cnt_d = cnt_q + 4'd1;
          end
        end
      end
      FePush: begin
        if (!full_i) begin
          push_o  = 1'b1;
          state_d = FeIdle;
        end
      end
      default: state_d = FeIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= FeIdle;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    work_q <= work_d;
  end

  assign work_o = work_q;

endmodule

/* rtl/ght_fifo.sv */
// ----------------------------------------------------------------------------
// ght_fifo
// Two-entry queue between the front and the back.
// ----------------------------------------------------------------------------
module ght_fifo import ght_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  work_t wdata_i,
  output logic  full_o,
  input  logic  pop_i,
  output logic  empty_o,
  output work_t rdata_o
);

  work_t      mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q;

  assign full_o  = cnt_q == 2'd2;
  assign empty_o = cnt_q == 2'd0;
  assign rdata_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop_i) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      cnt_q <= cnt_q + 2'(push_i) - 2'(pop_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule

/* rtl/ght_back.sv */
// ----------------------------------------------------------------------------
// ght_back
// Executes lookups, inserts and table growth against the entry store and
// holds the configuration registers and the result register.
// ----------------------------------------------------------------------------
module ght_back import ght_pkg::*; #(
  parameter int unsigned MaxBits = MaxBucketBits,
  parameter int unsigned MaxSize = MaxBucketSize
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_valid_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  input  logic                empty_i,
  input  work_t               work_i,
  output logic                pop_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output rsp_t                out_data_o
);

  localparam int unsigned NumBkt = 1 << MaxBits;
  localparam int unsigned Depth  = NumBkt * MaxSize;
  localparam int unsigned AddrW  = $clog2(Depth);
  localparam int unsigned FillW  = $clog2(MaxSize + 1);
  localparam int unsigned BktW   = MaxBits;
  localparam int unsigned BitsW  = $clog2(MaxBits + 1);
  localparam int unsigned TotW   = $clog2(Depth + 1);
  localparam int unsigned EntW   = KeyLowW + KeyHighW + ValueW + MaxBits;
  localparam logic [BitsW-1:0] BitsRst =
      (32'(InitBitsRst) > MaxBits) ? BitsW'(MaxBits) : BitsW'(InitBitsRst);

  be_state_e state_q, state_d;
  logic [InitBitsW-1:0] init_bits_q;
  logic [SizeRawW-1:0]  size_raw_q;
  logic [BitsW-1:0] bits_q, bits_d, bits_init;
  logic [TotW-1:0]  total_q, total_d;
  logic [FillW-1:0] fill_q [NumBkt];
  logic [FillW-1:0] size_eff;
  work_t item_q, item_d;
  logic [FillW-1:0] j_q, j_d, lo_q, lo_d, hi_q, hi_d;
  logic [BktW-1:0]  gb_q, gb_d, bmask, bkt, gb_hi, gb_last;
  logic out_valid_q, out_valid_d;
  rsp_t out_q, out_d;
  logic fa_we, fb_we;
  logic [BktW-1:0]  fa_idx, fb_idx;
  logic [FillW-1:0] fa_val, fb_val;
  logic ram_we, ram_re, split_bit, cfg_clear;
  logic [AddrW-1:0] waddr, raddr;
  logic [EntW-1:0]  wdata, rdata;
  logic [KeyLowW-1:0]  rd_key_low;
  logic [KeyHighW-1:0] rd_key_high;
  logic [ValueW-1:0]   rd_value;
  logic [MaxBits-1:0]  rd_hash;

  function automatic logic [AddrW-1:0] slot(logic [BktW-1:0] b, logic [FillW-1:0] p);
    return AddrW'(b) * AddrW'(MaxSize) + AddrW'(p);
  endfunction

  assign cfg_clear = cfg_valid_i &&
                     (cfg_index_i == CfgInitBits || cfg_index_i == CfgBucketSize);

  always_comb begin
    logic [InitBitsW-1:0] ib;
    ib = init_bits_q;
    if (cfg_valid_i && cfg_index_i == CfgInitBits) begin
      ib = cfg_data_i[InitBitsW-1:0];
    end
    bits_init = (32'(ib) > MaxBits) ? BitsW'(MaxBits) : BitsW'(ib);
  end

  assign size_eff = (32'(size_raw_q) > MaxSize) ? FillW'(MaxSize) : FillW'(size_raw_q);

  always_comb begin
    for (int i = 0; i < BktW; i++) begin
      bmask[i] = 32'(i) < 32'(bits_q);
    end
  end

  assign bkt     = item_q.hash[BktW-1:0] & bmask;
  assign gb_hi   = gb_q | BktW'(NumBkt'(1) << bits_q);
  assign gb_last = BktW'((NumBkt'(1) << bits_q) - 1);

  assign rd_key_low  = rdata[EntW-1 -: KeyLowW];
  assign rd_key_high = rdata[EntW-KeyLowW-1 -: KeyHighW];
  assign rd_value    = rdata[MaxBits+ValueW-1 -: ValueW];
  assign rd_hash     = rdata[MaxBits-1:0];

  always_comb begin
    split_bit = 1'b0;
    for (int i = 0; i < MaxBits; i++) begin
      if (32'(i) == 32'(bits_q)) begin
        split_bit = rd_hash[i];
      end
    end
  end

  assign wdata = (state_q == BeGrWr) ? rdata :
                 {item_q.key_low, item_q.key_high, item_q.value, item_q.hash[MaxBits-1:0]};

  always_comb begin
    state_d     = state_q;
    bits_d      = bits_q;
    total_d     = total_q;
    item_d      = item_q;
    j_d         = j_q;
    lo_d        = lo_q;
    hi_d        = hi_q;
    gb_d        = gb_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;
    pop_o       = 1'b0;
    fa_we       = 1'b0;
    fb_we       = 1'b0;
    fa_idx      = bkt;
    fb_idx      = gb_hi;
    fa_val      = fill_q[bkt] + FillW'(1);
    fb_val      = hi_q;
    ram_we      = 1'b0;
    ram_re      = 1'b0;
    waddr       = slot(bkt, fill_q[bkt]);
    raddr       = slot(bkt, j_q);
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    case (state_q)
      BeIdle: begin
        if (!out_valid_q && !empty_i) begin
          pop_o   = 1'b1;
          item_d  = work_i;
          j_d     = '0;
          state_d = (work_i.req_type == ReqInsert) ? BeInsChk : BeLkRd;
        end
      end
      BeLkRd: begin
        if (j_q >= fill_q[bkt] || 32'(j_q) >= MaxSize) begin
          out_d.status       = StNotFound;
          out_d.result_value = '1;
          out_valid_d        = 1'b1;
          state_d            = BeIdle;
        end else begin
          ram_re  = 1'b1;
          state_d = BeLkChk;
        end
      end
      BeLkChk: begin
        if (rd_key_low == item_q.key_low && rd_key_high == item_q.key_high) begin
          out_d.status       = StOk;
          out_d.result_value = rd_value;
          out_valid_d        = 1'b1;
          state_d            = BeIdle;
        end else begin
          j_d     = j_q + FillW'(1);
          state_d = BeLkRd;
        end
      end
      BeInsChk: begin
        if (32'(total_q) > ((32'(size_eff) << bits_q) >> 2) && 32'(bits_q) < MaxBits) begin
          gb_d    = '0;
          j_d     = '0;
          lo_d    = '0;
          hi_d    = '0;
          state_d = BeGrBkt;
        end else begin
          state_d = BeIns;
        end
      end
      BeGrBkt: begin
        raddr = slot(gb_q, j_q);
        if (j_q == fill_q[gb_q]) begin
          fa_we  = 1'b1;
          fa_idx = gb_q;
          fa_val = lo_q;
          fb_we  = 1'b1;
          j_d    = '0;
          lo_d   = '0;
          hi_d   = '0;
          if (gb_q == gb_last) begin
            bits_d  = bits_q + BitsW'(1);
            state_d = BeIns;
          end else begin
            gb_d = gb_q + BktW'(1);
          end
        end else begin
          ram_re  = 1'b1;
          state_d = BeGrWr;
        end
      end
      BeGrWr: begin
        ram_we = 1'b1;
        if (split_bit) begin
          waddr = slot(gb_hi, hi_q);
          hi_d  = hi_q + FillW'(1);
        end else begin
          waddr = slot(gb_q, lo_q);
          lo_d  = lo_q + FillW'(1);
        end
        j_d     = j_q + FillW'(1);
        state_d = BeGrBkt;
      end
      BeIns: begin
        out_d.result_value = '0;
        out_valid_d        = 1'b1;
        state_d            = BeIdle;
        if (fill_q[bkt] >= size_eff) begin
          out_d.status = StFull;
        end else begin
          out_d.status = StOk;
          ram_we       = 1'b1;
          fa_we        = 1'b1;
          total_d      = total_q + TotW'(1);
        end
      end
      default: state_d = BeIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BeIdle;
      init_bits_q <= InitBitsRst;
      size_raw_q  <= SizeRawRst;
      bits_q      <= BitsRst;
      total_q     <= '0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < NumBkt; i++) begin
        fill_q[i] <= '0;
      end
    end else if (cfg_clear) begin
      if (cfg_index_i == CfgInitBits) begin
        init_bits_q <= cfg_data_i[InitBitsW-1:0];
      end else begin
        size_raw_q <= cfg_data_i[SizeRawW-1:0];
      end
      state_q     <= BeIdle;
      bits_q      <= bits_init;
      total_q     <= '0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < NumBkt; i++) begin
        fill_q[i] <= '0;
      end
    end else begin
      state_q     <= state_d;
      bits_q      <= bits_d;
      total_q     <= total_d;
      out_valid_q <= out_valid_d;
      if (fa_we) begin
        fill_q[fa_idx] <= fa_val;
      end
      if (fb_we) begin
        fill_q[fb_idx] <= fb_val;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    item_q <= item_d;
    j_q    <= j_d;
    lo_q   <= lo_d;
    hi_q   <= hi_d;
    gb_q   <= gb_d;
    out_q  <= out_d;
  end

  ght_ram #(
    .Width(EntW),
    .Depth(Depth)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .re_i   (ram_re),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_pop_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |-> (state_q == BeIdle && !out_valid_q))
    else $error("Queue popped while the back end was busy.");

  a_total_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(total_q) <= Depth)
    else $error("Entry count exceeds the store depth.");

  a_bits_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(bits_q) <= MaxBits)
    else $error("Bucket bits exceed the maximum.");

  a_grow_below_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == BeGrBkt) |-> (32'(bits_q) < MaxBits))
    else $error("Growth started at the maximum bucket bits.");

endmodule
